>>> sv/rrpf_pkg.sv
package rrpf_pkg;

    // coordinate, offset, size, radius and tile widths
    localparam int COORD_W = 12;
    localparam int OFS_W   = 14;
    localparam int SIZE_W  = 11;
    localparam int RAD_W   = 10;
    localparam int SQ_W    = 2 * RAD_W;
    localparam int TILE_W  = 64;
    localparam int IDX_W   = 3;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_AREA_LEFT     = 3'd0;
    localparam logic [IDX_W-1:0] CFG_AREA_TOP      = 3'd1;
    localparam logic [IDX_W-1:0] CFG_AREA_WIDTH    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_AREA_HEIGHT   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_CORNER_RADIUS = 3'd4;
    localparam logic [IDX_W-1:0] CFG_TILE_BITS     = 3'd5;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [OFS_W-1:0]   ofs_t;

    typedef struct packed {
        coord_t              left;
        coord_t              top;
        logic [SIZE_W-1:0]   width;
        logic [SIZE_W-1:0]   height;
        logic [RAD_W-1:0]    radius;
        logic [TILE_W-1:0]   tile;
    } cfg_t;

    // offsets from the area origin
    typedef struct packed {
        ofs_t dx;
        ofs_t dy;
    } offset_t;

    // classified pixel: bounds, corner hit, tile bit, distances to centre
    typedef struct packed {
        logic             in_area;
        logic             corner;
        logic             pattern;
        logic [RAD_W-1:0] dist_x;
        logic [RAD_W-1:0] dist_y;
    } class_t;

    // squared distances
    typedef struct packed {
        logic            in_area;
        logic            corner;
        logic            pattern;
        logic [SQ_W-1:0] sq_x;
        logic [SQ_W-1:0] sq_y;
        logic [SQ_W-1:0] sq_r;
    } square_t;

endpackage

>>> sv/rrpf_cfg.sv
module rrpf_cfg (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [rrpf_pkg::IDX_W-1:0]  cfg_index,
    input  logic [rrpf_pkg::TILE_W-1:0] cfg_data,
    output rrpf_pkg::cfg_t           cfg
);
    import rrpf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_AREA_LEFT:     cfg_next.left   = coord_t'(cfg_data[COORD_W-1:0]);
                CFG_AREA_TOP:      cfg_next.top    = coord_t'(cfg_data[COORD_W-1:0]);
                CFG_AREA_WIDTH:    cfg_next.width  = cfg_data[SIZE_W-1:0];
                CFG_AREA_HEIGHT:   cfg_next.height = cfg_data[SIZE_W-1:0];
                CFG_CORNER_RADIUS: cfg_next.radius = cfg_data[RAD_W-1:0];
                CFG_TILE_BITS:     cfg_next.tile   = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/rrpf_offset.sv
module rrpf_offset (
    input  logic              clk,
    input  logic              rst_n,
    input  rrpf_pkg::cfg_t    cfg,
    input  logic              up_valid,
    output logic              up_ready,
    input  rrpf_pkg::coord_t  pixel_x,
    input  rrpf_pkg::coord_t  pixel_y,
    output logic              dn_valid,
    input  logic              dn_ready,
    output rrpf_pkg::offset_t dn_data
);
    import rrpf_pkg::*;

    logic    valid_reg;
    offset_t data_reg;
    offset_t data_next;

    always_comb
    begin
        data_next.dx = ofs_t'(pixel_x) - ofs_t'(cfg.left);
        data_next.dy = ofs_t'(pixel_y) - ofs_t'(cfg.top);
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

>>> sv/rrpf_classify.sv
module rrpf_classify (
    input  logic              clk,
    input  logic              rst_n,
    input  rrpf_pkg::cfg_t    cfg,
    input  logic              up_valid,
    output logic              up_ready,
    input  rrpf_pkg::offset_t up_data,
    output logic              dn_valid,
    input  logic              dn_ready,
    output rrpf_pkg::class_t  dn_data
);
    import rrpf_pkg::*;

    logic   valid_reg;
    class_t data_reg;
    class_t data_next;

    ofs_t w;
    ofs_t h;
    ofs_t r;
    ofs_t dist_l;
    ofs_t dist_r;
    ofs_t dist_t;
    ofs_t dist_b;
    logic in_l;
    logic in_r;
    logic in_t;
    logic in_b;
    logic sel_left;
    logic sel_top;
    logic hit;

    always_comb
    begin
        w = ofs_t'({1'b0, cfg.width});
        h = ofs_t'({1'b0, cfg.height});
        r = ofs_t'({1'b0, cfg.radius});

        in_l = up_data.dx < r;
        in_r = up_data.dx >= w - r;
        in_t = up_data.dy < r;
        in_b = up_data.dy >= h - r;

        // distances to the corner centres; 1..r inside a corner square
        dist_l = r - up_data.dx;
        dist_r = up_data.dx - w + r + 14'sd1;
        dist_t = r - up_data.dy;
        dist_b = up_data.dy - h + r + 14'sd1;

        // top-left, top-right, bottom-left, bottom-right: first match wins
        sel_left = 1'b0;
        sel_top  = 1'b0;
        hit      = 1'b1;
        priority if (in_l && in_t)
        begin
            sel_left = 1'b1;
            sel_top  = 1'b1;
        end
        else if (in_r && in_t)
        begin
            sel_top = 1'b1;
        end
        else if (in_l && in_b)
        begin
            sel_left = 1'b1;
        end
        else if (in_r && in_b)
        begin
            hit = 1'b1;
        end
        else
        begin
            hit = 1'b0;
        end

        data_next.in_area = (up_data.dx >= 14'sd0) && (up_data.dx < w)
                         && (up_data.dy >= 14'sd0) && (up_data.dy < h);
        data_next.corner = data_next.in_area && hit;
        // byte = row, bit 7 is column 0
        data_next.pattern = cfg.tile[{up_data.dy[2:0], ~up_data.dx[2:0]}];
        data_next.dist_x  = sel_left ? dist_l[RAD_W-1:0] : dist_r[RAD_W-1:0];
        data_next.dist_y  = sel_top  ? dist_t[RAD_W-1:0] : dist_b[RAD_W-1:0];
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

>>> sv/rrpf_clip.sv
module rrpf_clip (
    input  logic             clk,
    input  logic             rst_n,
    input  rrpf_pkg::cfg_t   cfg,
    input  logic             up_valid,
    output logic             up_ready,
    input  rrpf_pkg::class_t up_data,
    output logic             dn_valid,
    input  logic             dn_ready,
    output logic             ink,
    output logic             inside_area,
    output logic             corner_clipped
);
    import rrpf_pkg::*;

    logic    sq_valid_reg;
    square_t sq_reg;
    square_t sq_next;
    logic    sq_ready;

    logic    out_valid_reg;
    logic    ink_reg;
    logic    inside_reg;
    logic    clipped_reg;
    logic    ink_next;
    logic    clipped_next;
    logic [SQ_W:0] sum;

    // squaring stage
    always_comb
    begin
        sq_next.in_area = up_data.in_area;
        sq_next.corner  = up_data.corner;
        sq_next.pattern = up_data.pattern;
        sq_next.sq_x    = {{RAD_W{1'b0}}, up_data.dist_x} * {{RAD_W{1'b0}}, up_data.dist_x};
        sq_next.sq_y    = {{RAD_W{1'b0}}, up_data.dist_y} * {{RAD_W{1'b0}}, up_data.dist_y};
        sq_next.sq_r    = {{RAD_W{1'b0}}, cfg.radius} * {{RAD_W{1'b0}}, cfg.radius};
    end

    assign up_ready = !sq_valid_reg || sq_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            sq_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            sq_reg <= sq_next;
        end
    end

    // compare and output stage
    always_comb
    begin
        sum          = {1'b0, sq_reg.sq_x} + {1'b0, sq_reg.sq_y};
        clipped_next = sq_reg.corner && (sum > {1'b0, sq_reg.sq_r});
        ink_next     = sq_reg.in_area && !clipped_next && sq_reg.pattern;
    end

    assign sq_ready = !out_valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (sq_ready)
        begin
            out_valid_reg <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_ready && sq_valid_reg)
        begin
            ink_reg     <= ink_next;
            inside_reg  <= sq_reg.in_area;
            clipped_reg <= clipped_next;
        end
    end

    assign dn_valid       = out_valid_reg;
    assign ink            = ink_reg;
    assign inside_area    = inside_reg;
    assign corner_clipped = clipped_reg;

endmodule

>>> sv/rounded_rect_pattern_fill.sv
// Rounded-rectangle fill with an 8x8 tile pattern.
// Input channel: pixel_x/pixel_y with in_valid; the block holds in_stall high
// when it cannot take the item. Output channel: ink, inside_area and
// corner_clipped with out_valid; the receiver holds out_stall high to stall.
// Configuration: cfg_write with cfg_index (0 left, 1 top, 2 width, 3 height,
// 4 corner radius, 5 tile bits) and cfg_data; write only while the block is
// empty. Reset clears the configuration registers to zero.
// Path: the offset register loads on the accepting edge, then the classify,
// square and compare registers in turn; out_valid comes from the last one.
// Throughput: one item per clock; every stage is a register with its own
// valid bit, so a new item enters every cycle the pipe is moving.
// Stall: each stage loads whenever it is empty or the next one moves, so
// bubbles are squeezed out; in_stall rises only with all four stages full
// and out_stall high. Nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) empties the pipe and clears the configuration.
module rounded_rect_pattern_fill (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [rrpf_pkg::IDX_W-1:0]  cfg_index,
    input  logic [rrpf_pkg::TILE_W-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [11:0]          pixel_x,
    input  logic signed [11:0]          pixel_y,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        ink,
    output logic                        inside_area,
    output logic                        corner_clipped
);
    import rrpf_pkg::*;

    cfg_t    cfg;

    // stage handshakes
    logic    s1_ready;
    logic    s1_valid;
    offset_t s1_data;
    logic    s2_ready;
    logic    s2_valid;
    class_t  s2_data;
    logic    s3_ready;

    rrpf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // offsets from the area origin
    rrpf_offset u_offset (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (in_valid),
        .up_ready (s1_ready),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .dn_valid (s1_valid),
        .dn_ready (s2_ready),
        .dn_data  (s1_data)
    );

    // bounds, corner choice, distances to the centre, tile bit
    rrpf_classify u_classify (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (s1_valid),
        .up_ready (s2_ready),
        .up_data  (s1_data),
        .dn_valid (s2_valid),
        .dn_ready (s3_ready),
        .dn_data  (s2_data)
    );

    // squares, circle test and output register
    rrpf_clip u_clip (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .up_valid       (s2_valid),
        .up_ready       (s3_ready),
        .up_data        (s2_data),
        .dn_valid       (out_valid),
        .dn_ready       (!out_stall),
        .ink            (ink),
        .inside_area    (inside_area),
        .corner_clipped (corner_clipped)
    );

    assign in_stall = !s1_ready;

`ifndef SYNTHESIS
    a_clip_inside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && corner_clipped |-> inside_area)
        else $error("corner clip on a pixel outside the area");

    a_ink_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ink |-> inside_area && !corner_clipped)
        else $error("ink on an outside or clipped pixel");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall && s1_valid && s2_valid)
        else $error("input stalled while the pipe has room");
`endif

endmodule
